/* hdl/misaligned_access_decode_check_macros.svh */
// Assertion macros for the misaligned access decode and check block.
// Used by the top level; expects a clock named clk and a reset named arst_n in scope.
`ifndef MISALIGNED_ACCESS_DECODE_CHECK_MACROS_SVH
`define MISALIGNED_ACCESS_DECODE_CHECK_MACROS_SVH
`ifndef ASSERT_OFF
// Checked while out of reset only.
`define MADC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define MADC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MADC_ASSERT(lbl, prop, msg)
`define MADC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hdl/madc_pkg.sv */
// Shared types and codes for the misaligned access decode and check block.
// No dependencies.
package madc_pkg;

	localparam int MADC_EFFECTIVE_BITS = 32;
	localparam logic [31:0] MADC_USER_LIMIT_RST = 32'h8000_0000;

	// Configuration register indexes
	localparam logic CFG_FIXUP_ENABLE = 1'b0;
	localparam logic CFG_USER_LIMIT   = 1'b1;

	// Fault codes
	localparam logic [2:0] FAULT_OK         = 3'd0;
	localparam logic [2:0] FAULT_FIXUP_OFF  = 3'd1;
	localparam logic [2:0] FAULT_BAD_PC     = 3'd2;
	localparam logic [2:0] FAULT_UNKNOWN_OP = 3'd3;
	localparam logic [2:0] FAULT_NOT_SEXT   = 3'd4;
	localparam logic [2:0] FAULT_OVER_LIMIT = 3'd5;
	localparam logic [2:0] FAULT_FPU_KERNEL = 3'd6;

	// Access classes
	localparam logic [1:0] CLS_LOAD   = 2'd0;
	localparam logic [1:0] CLS_STORE  = 2'd1;
	localparam logic [1:0] CLS_FLOAD  = 2'd2;
	localparam logic [1:0] CLS_FSTORE = 2'd3;

	// ISA mode marked in pc[1:0]
	localparam logic [1:0] PC_MODE_32 = 2'd1;

	// Major opcodes, bits 31..26
	localparam logic [5:0] MAJ_LDW   = 6'h21;
	localparam logic [5:0] MAJ_LDUW  = 6'h2c;
	localparam logic [5:0] MAJ_LDL   = 6'h22;
	localparam logic [5:0] MAJ_LDQ   = 6'h23;
	localparam logic [5:0] MAJ_STW   = 6'h29;
	localparam logic [5:0] MAJ_STL   = 6'h2a;
	localparam logic [5:0] MAJ_STQ   = 6'h2b;
	localparam logic [5:0] MAJ_LDX   = 6'h10;
	localparam logic [5:0] MAJ_STX   = 6'h18;
	localparam logic [5:0] MAJ_FLDS  = 6'h25;
	localparam logic [5:0] MAJ_FLDP  = 6'h26;
	localparam logic [5:0] MAJ_FLDD  = 6'h27;
	localparam logic [5:0] MAJ_FLDX  = 6'h07;
	localparam logic [5:0] MAJ_FSTS  = 6'h2d;
	localparam logic [5:0] MAJ_FSTP  = 6'h2e;
	localparam logic [5:0] MAJ_FSTD  = 6'h2f;
	localparam logic [5:0] MAJ_FSTX  = 6'h0f;

	// Minor opcodes, bits 19..16, indexed forms
	localparam logic [3:0] MIN_W   = 4'h1;
	localparam logic [3:0] MIN_UW  = 4'h5;
	localparam logic [3:0] MIN_L   = 4'h2;
	localparam logic [3:0] MIN_Q   = 4'h3;
	localparam logic [3:0] MIN_FS  = 4'h8;
	localparam logic [3:0] MIN_FP  = 4'hd;
	localparam logic [3:0] MIN_FD  = 4'h9;

	typedef struct packed {
		logic [63:0] pc;
		logic [31:0] opcode;
		logic        from_user;
		logic [63:0] base_value;
		logic [63:0] index_value;
	} madc_in_t;

	typedef struct packed {
		logic [2:0]  fault_code;
		logic [1:0]  op_class;
		logic [1:0]  size_shift;
		logic        sign_extend;
		logic        paired;
		logic [63:0] eff_address;
		logic [5:0]  data_reg;
		logic [63:0] next_pc;
	} madc_out_t;

	typedef struct packed {
		logic       known;
		logic       indexed;
		logic [1:0] cls;
		logic [1:0] shift;
		logic       sext;
		logic       pair;
	} madc_kind_t;

endpackage

/* hdl/madc_decode.sv */
// Opcode decoder: major and minor fields to access kind.
// Depends on madc_pkg.
module madc_decode
	import madc_pkg::*;
(
	input  logic [31:0] opcode,
	output madc_kind_t  kind
);

	logic [5:0] major;
	logic [3:0] minor;

	assign major = opcode[31:26];
	assign minor = opcode[19:16];

	function automatic madc_kind_t mk(logic idx, logic [1:0] cls, logic [1:0] sh,
			logic sx, logic pr);
		madc_kind_t k;
		k.known   = 1'b1;
		k.indexed = idx;
		k.cls     = cls;
		k.shift   = sh;
		k.sext    = sx;
		k.pair    = pr;
		return k;
	endfunction

	always_comb begin
		kind = '0;
		unique case (major)
			MAJ_LDW:  kind = mk(1'b0, CLS_LOAD, 2'd1, 1'b1, 1'b0);
			MAJ_LDUW: kind = mk(1'b0, CLS_LOAD, 2'd1, 1'b0, 1'b0);
			MAJ_LDL:  kind = mk(1'b0, CLS_LOAD, 2'd2, 1'b1, 1'b0);
			MAJ_LDQ:  kind = mk(1'b0, CLS_LOAD, 2'd3, 1'b0, 1'b0);
			MAJ_STW:  kind = mk(1'b0, CLS_STORE, 2'd1, 1'b0, 1'b0);
			MAJ_STL:  kind = mk(1'b0, CLS_STORE, 2'd2, 1'b0, 1'b0);
			MAJ_STQ:  kind = mk(1'b0, CLS_STORE, 2'd3, 1'b0, 1'b0);
			MAJ_LDX: begin
				unique case (minor)
					MIN_W:   kind = mk(1'b1, CLS_LOAD, 2'd1, 1'b1, 1'b0);
					MIN_UW:  kind = mk(1'b1, CLS_LOAD, 2'd1, 1'b0, 1'b0);
					MIN_L:   kind = mk(1'b1, CLS_LOAD, 2'd2, 1'b1, 1'b0);
					MIN_Q:   kind = mk(1'b1, CLS_LOAD, 2'd3, 1'b0, 1'b0);
					default: kind = '0;
				endcase
			end
			MAJ_STX: begin
				unique case (minor)
					MIN_W:   kind = mk(1'b1, CLS_STORE, 2'd1, 1'b0, 1'b0);
					MIN_L:   kind = mk(1'b1, CLS_STORE, 2'd2, 1'b0, 1'b0);
					MIN_Q:   kind = mk(1'b1, CLS_STORE, 2'd3, 1'b0, 1'b0);
					default: kind = '0;
				endcase
			end
			MAJ_FLDS: kind = mk(1'b0, CLS_FLOAD, 2'd2, 1'b0, 1'b0);
			MAJ_FLDP: kind = mk(1'b0, CLS_FLOAD, 2'd3, 1'b0, 1'b1);
			MAJ_FLDD: kind = mk(1'b0, CLS_FLOAD, 2'd3, 1'b0, 1'b0);
			MAJ_FLDX: begin
				unique case (minor)
					MIN_FS:  kind = mk(1'b1, CLS_FLOAD, 2'd2, 1'b0, 1'b0);
					MIN_FP:  kind = mk(1'b1, CLS_FLOAD, 2'd3, 1'b0, 1'b1);
					MIN_FD:  kind = mk(1'b1, CLS_FLOAD, 2'd3, 1'b0, 1'b0);
					default: kind = '0;
				endcase
			end
			MAJ_FSTS: kind = mk(1'b0, CLS_FSTORE, 2'd2, 1'b0, 1'b0);
			MAJ_FSTP: kind = mk(1'b0, CLS_FSTORE, 2'd3, 1'b0, 1'b1);
			MAJ_FSTD: kind = mk(1'b0, CLS_FSTORE, 2'd3, 1'b0, 1'b0);
			MAJ_FSTX: begin
				unique case (minor)
					MIN_FS:  kind = mk(1'b1, CLS_FSTORE, 2'd2, 1'b0, 1'b0);
					MIN_FP:  kind = mk(1'b1, CLS_FSTORE, 2'd3, 1'b0, 1'b1);
					MIN_FD:  kind = mk(1'b1, CLS_FSTORE, 2'd3, 1'b0, 1'b0);
					default: kind = '0;
				endcase
			end
			default: kind = '0;
		endcase
	end

endmodule

/* hdl/madc_check.sv */
// Effective address forming and fault prioritization for one decoded access.
// Depends on madc_pkg.
module madc_check
	import madc_pkg::*;
#(
	parameter int EFFECTIVE_BITS = MADC_EFFECTIVE_BITS
) (
	input  madc_in_t    item,
	input  madc_kind_t  kind,
	input  logic        fixup_enable,
	input  logic [31:0] user_limit,
	output madc_out_t   result
);

	// Bits 63 down to EFFECTIVE_BITS-1 must all match
	localparam int TOP_W = 65 - EFFECTIVE_BITS;

	logic [63:0]      disp_sx;
	logic [63:0]      addend;
	logic [63:0]      addr;
	logic [TOP_W-1:0] addr_top;
	logic             sext_ok;
	logic             over_limit;
	logic [2:0]       code;
	logic             early;

	assign disp_sx  = {{54{item.opcode[19]}}, item.opcode[19:10]};
	assign addend   = kind.indexed ? item.index_value : (disp_sx << kind.shift);
	assign addr     = item.base_value + addend;
	assign addr_top = addr[63 -: TOP_W];
	assign sext_ok  = (addr_top == '0) || (addr_top == '1);
	assign over_limit = addr >= {32'd0, user_limit};

	always_comb begin
		if (!fixup_enable) begin
			code = FAULT_FIXUP_OFF;
		end else if (item.pc[1:0] != PC_MODE_32) begin
			code = FAULT_BAD_PC;
		end else if (!kind.known) begin
			code = FAULT_UNKNOWN_OP;
		end else if (!sext_ok) begin
			code = FAULT_NOT_SEXT;
		end else if (item.from_user && over_limit) begin
			code = FAULT_OVER_LIMIT;
		end else if (!item.from_user && kind.cls[1]) begin
			code = FAULT_FPU_KERNEL;
		end else begin
			code = FAULT_OK;
		end
	end

	assign early = (code == FAULT_FIXUP_OFF) || (code == FAULT_BAD_PC) ||
		(code == FAULT_UNKNOWN_OP);

	always_comb begin
		result.fault_code  = code;
		result.op_class    = early ? '0 : kind.cls;
		result.size_shift  = early ? '0 : kind.shift;
		result.sign_extend = early ? 1'b0 : kind.sext;
		result.paired      = early ? 1'b0 : kind.pair;
		result.eff_address = early ? '0 : addr;
		result.data_reg    = early ? '0 : item.opcode[9:4];
		result.next_pc     = (code == FAULT_OK) ? item.pc + 64'd4 : item.pc;
	end

endmodule

/* hdl/misaligned_access_decode_check.sv */
// Misaligned access decode and check: input register, decode and check, result register.
// The input register captures an accepted transfer; the result register holds its result
// and drives result_valid. Throughput: one transfer every cycle, set by one registered
// pass of decode, a 64-bit add and the limit compare; busy stays low, nothing is held off.
// Reset (arst_n low, asynchronous) clears the valid flags, sets fixup_enable to 1 and
// user_limit to 0x80000000. Depends on madc_pkg, madc_decode, madc_check and the macros.
`include "misaligned_access_decode_check_macros.svh"
module misaligned_access_decode_check
	import madc_pkg::*;
#(
	parameter int EFFECTIVE_BITS = MADC_EFFECTIVE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  madc_in_t    item,
	output logic        result_valid,
	output madc_out_t   result,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata
);

	logic        fixup_enable_q;
	logic [31:0] user_limit_q;

	logic        valid_s1;
	madc_in_t    item_s1;
	logic        valid_s2;
	madc_out_t   result_s2;

	madc_kind_t  kind;
	madc_out_t   result_next;
	logic        take;

	// Every cycle is open for a new transfer: both stages advance unconditionally.
	assign busy = 1'b0;
	assign take = start && !busy;

	// Writes land directly; the user must write only with nothing in flight; not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixup_enable_q <= 1'b1;
			user_limit_q   <= MADC_USER_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIXUP_ENABLE: fixup_enable_q <= cfg_wdata[0];
				CFG_USER_LIMIT:   user_limit_q   <= cfg_wdata;
				default:          ;
			endcase
		end
	end

	// Stage 1: capture the trapping instruction and its operands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	madc_decode u_decode (
		.opcode (item_s1.opcode),
		.kind   (kind)
	);

	madc_check #(
		.EFFECTIVE_BITS (EFFECTIVE_BITS)
	) u_check (
		.item         (item_s1),
		.kind         (kind),
		.fixup_enable (fixup_enable_q),
		.user_limit   (user_limit_q),
		.result       (result_next)
	);

	// Stage 2: hold the finished result for exactly one cycle of strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= result_next;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// Every captured item yields exactly one result in the following cycle.
	`MADC_ASSERT(a_stage_advance, valid_s1 |=> result_valid, "stage 1 item produced no result")
	`MADC_ASSERT_ALWAYS(a_no_phantom, !valid_s1 |=> !result_valid, "result without an item")
	// Early faults clear the decoded fields and the address.
	`MADC_ASSERT(a_early_zero,
		result_valid && (result.fault_code == FAULT_FIXUP_OFF ||
		result.fault_code == FAULT_BAD_PC || result.fault_code == FAULT_UNKNOWN_OP)
		|-> (result.eff_address == '0 && result.op_class == '0 && result.data_reg == '0),
		"early fault left decoded fields set")
	// A kernel FPU fault comes only from an FPU class.
	`MADC_ASSERT(a_fpu_kernel_cls,
		result_valid && result.fault_code == FAULT_FPU_KERNEL |-> result.op_class[1],
		"fpu-in-kernel fault on integer access")
	// With fixups off every result reports that fault first.
	`MADC_ASSERT(a_fixup_off,
		result_valid && !fixup_enable_q |-> result.fault_code == FAULT_FIXUP_OFF,
		"fixup disabled but another code reported")

endmodule

/* dv/tb.sv */
// Self-checking bench for misaligned_access_decode_check: directed and random transfers,
// with an in-bench decode and address check predicting each result.
// Depends on madc_pkg and the block's RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import madc_pkg::*;

	localparam int EFF_BITS     = MADC_EFFECTIVE_BITS;
	localparam int NUM_OPS      = 26;      // every listed major/minor combination
	localparam int PIPE_CYCLES  = 4;       // two-stage pipe plus margin
	localparam int CYCLE_LIMIT  = 200_000;

	// Filler minor for non-indexed forms, and minors no indexed major accepts
	localparam logic [3:0] NO_MINOR      = 4'h0;
	localparam logic [3:0] BAD_MINOR_LO  = 4'h0;
	localparam logic [3:0] BAD_MINOR_HI  = 4'hf;
	localparam logic [5:0] MAJ_UNLISTED  = 6'h3f;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	madc_in_t    item = '0;
	logic        result_valid;
	madc_out_t   result;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_FIXUP_ENABLE;
	logic [31:0] cfg_wdata = '0;

	// Bench copy of the configuration registers, changed only while the block is idle
	logic        cfg_fixup = 1'b1;
	logic [31:0] cfg_limit = MADC_USER_LIMIT_RST;

	madc_in_t  pending_items[$];
	madc_out_t expected_results[$];

	int  sent_count = 0;
	int  checked_count = 0;
	int  mismatch_count = 0;
	int  setting_count = 0;
	int  cycle_count = 0;
	int  code_hits[8];
	int  burst_left = 0;
	int  gap_left = 0;
	bit  drain_wait = 1'b0;
	madc_out_t want;

	misaligned_access_decode_check #(
		.EFFECTIVE_BITS(EFF_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Operation table: {indexed, major, minor}. Non-indexed forms leave the minor alone.
	function automatic logic [10:0] known_op(input int sel);
		case (sel)
			0:  return {1'b0, MAJ_LDW,  NO_MINOR};
			1:  return {1'b0, MAJ_LDUW, NO_MINOR};
			2:  return {1'b0, MAJ_LDL,  NO_MINOR};
			3:  return {1'b0, MAJ_LDQ,  NO_MINOR};
			4:  return {1'b0, MAJ_STW,  NO_MINOR};
			5:  return {1'b0, MAJ_STL,  NO_MINOR};
			6:  return {1'b0, MAJ_STQ,  NO_MINOR};
			7:  return {1'b0, MAJ_FLDS, NO_MINOR};
			8:  return {1'b0, MAJ_FLDP, NO_MINOR};
			9:  return {1'b0, MAJ_FLDD, NO_MINOR};
			10: return {1'b0, MAJ_FSTS, NO_MINOR};
			11: return {1'b0, MAJ_FSTP, NO_MINOR};
			12: return {1'b0, MAJ_FSTD, NO_MINOR};
			13: return {1'b1, MAJ_LDX,  MIN_W};
			14: return {1'b1, MAJ_LDX,  MIN_UW};
			15: return {1'b1, MAJ_LDX,  MIN_L};
			16: return {1'b1, MAJ_LDX,  MIN_Q};
			17: return {1'b1, MAJ_STX,  MIN_W};
			18: return {1'b1, MAJ_STX,  MIN_L};
			19: return {1'b1, MAJ_STX,  MIN_Q};
			20: return {1'b1, MAJ_FLDX, MIN_FS};
			21: return {1'b1, MAJ_FLDX, MIN_FP};
			22: return {1'b1, MAJ_FLDX, MIN_FD};
			23: return {1'b1, MAJ_FSTX, MIN_FS};
			24: return {1'b1, MAJ_FSTX, MIN_FP};
			default: return {1'b1, MAJ_FSTX, MIN_FD};
		endcase
	endfunction

	// Decode the major and minor fields into class, width and flags
	function automatic madc_kind_t decode_access(input logic [31:0] op);
		madc_kind_t k;
		k = '0;
		k.known = 1'b1;
		case (op[31:26]) inside
			MAJ_LDW:  begin k.cls = CLS_LOAD; k.shift = 2'd1; k.sext = 1'b1; end
			MAJ_LDUW: begin k.cls = CLS_LOAD; k.shift = 2'd1; end
			MAJ_LDL:  begin k.cls = CLS_LOAD; k.shift = 2'd2; k.sext = 1'b1; end
			MAJ_LDQ:  begin k.cls = CLS_LOAD; k.shift = 2'd3; end
			MAJ_STW:  begin k.cls = CLS_STORE; k.shift = 2'd1; end
			MAJ_STL:  begin k.cls = CLS_STORE; k.shift = 2'd2; end
			MAJ_STQ:  begin k.cls = CLS_STORE; k.shift = 2'd3; end
			MAJ_FLDS: begin k.cls = CLS_FLOAD; k.shift = 2'd2; end
			MAJ_FLDP: begin k.cls = CLS_FLOAD; k.shift = 2'd3; k.pair = 1'b1; end
			MAJ_FLDD: begin k.cls = CLS_FLOAD; k.shift = 2'd3; end
			MAJ_FSTS: begin k.cls = CLS_FSTORE; k.shift = 2'd2; end
			MAJ_FSTP: begin k.cls = CLS_FSTORE; k.shift = 2'd3; k.pair = 1'b1; end
			MAJ_FSTD: begin k.cls = CLS_FSTORE; k.shift = 2'd3; end
			MAJ_LDX: begin
				k.indexed = 1'b1;
				k.cls = CLS_LOAD;
				case (op[19:16])
					MIN_W:  begin k.shift = 2'd1; k.sext = 1'b1; end
					MIN_UW: k.shift = 2'd1;
					MIN_L:  begin k.shift = 2'd2; k.sext = 1'b1; end
					MIN_Q:  k.shift = 2'd3;
					default: k.known = 1'b0;
				endcase
			end
			MAJ_STX: begin
				k.indexed = 1'b1;
				k.cls = CLS_STORE;
				case (op[19:16])
					MIN_W: k.shift = 2'd1;
					MIN_L: k.shift = 2'd2;
					MIN_Q: k.shift = 2'd3;
					default: k.known = 1'b0;
				endcase
			end
			MAJ_FLDX, MAJ_FSTX: begin
				k.indexed = 1'b1;
				k.cls = (op[31:26] == MAJ_FLDX) ? CLS_FLOAD : CLS_FSTORE;
				case (op[19:16])
					MIN_FS: k.shift = 2'd2;
					MIN_FP: begin k.shift = 2'd3; k.pair = 1'b1; end
					MIN_FD: k.shift = 2'd3;
					default: k.known = 1'b0;
				endcase
			end
			default: k.known = 1'b0;
		endcase
		return k;
	endfunction

	// Full prediction of one result from one transfer and the current settings
	function automatic madc_out_t predict_result(input madc_in_t t, input logic fix_en,
			input logic [31:0] limit);
		madc_out_t r;
		madc_kind_t k;
		logic [63:0] disp;
		logic [63:0] addr;
		logic [63:0] top_mask;
		logic [63:0] top;
		r = '0;
		k = decode_access(t.opcode);
		disp = {{54{t.opcode[19]}}, t.opcode[19:10]} << k.shift;
		addr = k.indexed ? t.base_value + t.index_value : t.base_value + disp;
		top_mask = ~64'd0 << (EFF_BITS - 1);
		top = addr & top_mask;
		if (!fix_en) begin
			r.fault_code = FAULT_FIXUP_OFF;
		end else if (t.pc[1:0] != PC_MODE_32) begin
			r.fault_code = FAULT_BAD_PC;
		end else if (!k.known) begin
			r.fault_code = FAULT_UNKNOWN_OP;
		end else begin
			if (top != '0 && top != top_mask)
				r.fault_code = FAULT_NOT_SEXT;
			else if (t.from_user && addr >= {32'd0, limit})
				r.fault_code = FAULT_OVER_LIMIT;
			else if (!t.from_user && (k.cls == CLS_FLOAD || k.cls == CLS_FSTORE))
				r.fault_code = FAULT_FPU_KERNEL;
			else
				r.fault_code = FAULT_OK;
			// late faults still carry the decode and the address
			r.op_class    = k.cls;
			r.size_shift  = k.shift;
			r.sign_extend = k.sext;
			r.paired      = k.pair;
			r.eff_address = addr;
			r.data_reg    = t.opcode[9:4];
		end
		r.next_pc = (r.fault_code == FAULT_OK) ? t.pc + 64'd4 : t.pc;
		return r;
	endfunction

	// Random transfer, biased toward valid ops in 32-bit mode with addresses near the
	// sign-extension edge and the user limit; the rest is raw noise.
	function automatic madc_in_t random_transfer(input logic [31:0] limit);
		madc_in_t t;
		logic [10:0] op;
		logic [31:0] r;
		logic [31:0] s;
		t.pc          = {$urandom, $urandom};
		t.opcode      = $urandom;
		t.from_user   = 1'($urandom_range(0, 1));
		t.base_value  = {$urandom, $urandom};
		t.index_value = {$urandom, $urandom};
		r = $urandom;
		s = $urandom;
		if ($urandom_range(0, 9) != 0)
			t.pc[1:0] = PC_MODE_32;
		if ($urandom_range(0, 7) != 0) begin
			op = known_op($urandom_range(0, NUM_OPS - 1));
			t.opcode[31:26] = op[9:4];
			if (op[10])
				t.opcode[19:16] = op[3:0];
		end
		case ($urandom_range(0, 9)) inside
			[0:3]: begin
				t.base_value  = {{32{r[31]}}, r};
				t.index_value = {{52{s[11]}}, s[11:0]};
			end
			[4:6]: begin
				t.base_value  = {32'd0, limit} + {{52{r[11]}}, r[11:0]};
				t.index_value = {{52{s[11]}}, s[11:0]};
			end
			7: begin
				t.base_value  = {33'd0, r[30:0]};
				t.index_value = {{52{s[11]}}, s[11:0]};
			end
			default: ;
		endcase
		return t;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
			mismatch_count++;
		end
	endtask

	// Write one register; only ever called with nothing in flight
	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FIXUP_ENABLE)
			cfg_fixup = val[0];
		else
			cfg_limit = val;
	endtask

	// Hold until every queued transfer went out and every result came back
	task automatic wait_idle();
		while (pending_items.size() != 0 || expected_results.size() != 0 || start)
			@(posedge clk);
		repeat (PIPE_CYCLES) @(posedge clk);
	endtask

	// Driver: one transfer per cycle in bursts; between bursts either a short gap,
	// no gap at all, or a full drain of the results outstanding.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item  <= '0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(predict_result(item, cfg_fixup, cfg_limit));
				sent_count++;
			end
			if (start && busy) begin
				// hold the offered transfer until it is taken
			end else if (gap_left != 0) begin
				gap_left--;
				start <= 1'b0;
			end else if ((drain_wait && expected_results.size() != 0)
					|| pending_items.size() == 0) begin
				start <= 1'b0;
			end else begin
				drain_wait = 1'b0;
				start <= 1'b1;
				item  <= pending_items.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					case ($urandom_range(0, 7)) inside
						[0:1]: gap_left = 0;
						2: drain_wait = 1'b1;
						default: gap_left = $urandom_range(1, 6);
					endcase
				end
			end
		end
	end

	// Monitor: the receiver cannot stall, so every strobed result is taken and
	// compared against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_results.size() == 0) begin
				$error("result with no transfer outstanding: fault_code 0x%0h",
					result.fault_code);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				checked_count++;
				code_hits[want.fault_code]++;
				check_field("fault_code", 64'(want.fault_code), 64'(result.fault_code));
				check_field("op_class", 64'(want.op_class), 64'(result.op_class));
				check_field("size_shift", 64'(want.size_shift), 64'(result.size_shift));
				check_field("sign_extend", 64'(want.sign_extend), 64'(result.sign_extend));
				check_field("paired", 64'(want.paired), 64'(result.paired));
				check_field("eff_address", want.eff_address, result.eff_address);
				check_field("data_reg", 64'(want.data_reg), 64'(result.data_reg));
				check_field("next_pc", want.next_pc, result.next_pc);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$error("run exceeded %0d cycles", CYCLE_LIMIT);
			$display("** misaligned_access_decode_check: FAILED **");
			$finish;
		end
	end

	initial begin
		madc_in_t t;
		logic [10:0] op;
		logic        fix;
		logic [31:0] lim;
		int          n_items;

		foreach (code_hits[k]) code_hits[k] = 0;

		// Hold reset, then release away from the active edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under reset settings: every operation once, rotating through
		// an in-range user access, a kernel access with the most negative displacement,
		// a user access over the limit and an address that is not sign-extended.
		for (int i = 0; i < NUM_OPS; i++) begin
			op = known_op(i);
			t.pc = {$urandom, $urandom};
			t.pc[1:0] = PC_MODE_32;
			t.opcode = $urandom;
			case (i % 4)
				0: begin
					t.from_user = 1'b1;
					t.base_value = '0;
					t.index_value = 64'h0000_0000_7fff_0000;
					t.opcode[19:10] = 10'h1ff;
				end
				1: begin
					t.from_user = 1'b0;
					t.base_value = 64'h0000_0000_7fff_ffff;
					t.index_value = '1;
					t.opcode[19:10] = 10'h200;
				end
				2: begin
					t.from_user = 1'b1;
					t.base_value = 64'hffff_ffff_8000_0000;
					t.index_value = '0;
					t.opcode[19:10] = '0;
				end
				default: begin
					t.from_user = 1'b0;
					t.base_value = 64'h0000_0000_7fff_fff0;
					t.index_value = 64'h0000_0000_7fff_ffff;
					t.opcode[19:10] = 10'h1ff;
				end
			endcase
			t.opcode[31:26] = op[9:4];
			if (op[10])
				t.opcode[19:16] = op[3:0];
			pending_items.push_back(t);
		end

		// pc at the top of the address space: next pc wraps around
		t = '0;
		t.pc = 64'hffff_ffff_ffff_fffd;
		t.opcode = {MAJ_LDQ, 26'd0};
		t.base_value = 64'h0000_0000_0000_1000;
		pending_items.push_back(t);

		// Wrong ISA mode in the pc: all zeros, all ones, and mode two
		t = '0;
		pending_items.push_back(t);
		t = '1;
		pending_items.push_back(t);
		t.pc = {$urandom, $urandom};
		t.pc[1:0] = ~PC_MODE_32;
		t.opcode = {MAJ_STQ, 26'd0};
		pending_items.push_back(t);

		// Unlisted major, and indexed majors with unlisted minors
		t = '1;
		t.pc[1:0] = PC_MODE_32;
		t.opcode[31:26] = MAJ_UNLISTED;
		pending_items.push_back(t);
		t.opcode[31:26] = MAJ_LDX;
		t.opcode[19:16] = BAD_MINOR_LO;
		pending_items.push_back(t);
		t.opcode[31:26] = MAJ_FSTX;
		t.opcode[19:16] = BAD_MINOR_HI;
		pending_items.push_back(t);
		setting_count++;

		// Random phases, each under its own settings; the extremes of the limit and
		// the fixup switch both ways are among them.
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin fix = 1'b1; lim = MADC_USER_LIMIT_RST; n_items = 400; end
				1: begin fix = 1'b1; lim = '0;                  n_items = 250; end
				2: begin fix = 1'b1; lim = '1;                  n_items = 400; end
				3: begin fix = 1'b0; lim = $urandom;            n_items = 150; end
				4: begin fix = 1'b1; lim = $urandom;            n_items = 350; end
				default: begin fix = 1'b1; lim = 32'h0001_0000; n_items = 350; end
			endcase
			wait_idle();
			write_reg(CFG_FIXUP_ENABLE, {31'd0, fix});
			write_reg(CFG_USER_LIMIT, lim);
			setting_count++;
			for (int n = 0; n < n_items; n++)
				pending_items.push_back(random_transfer(cfg_limit));
		end

		// Drain and let the pipe settle before judging
		wait_idle();
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			mismatch_count++;
		end

		$display("Sent %0d transfers, checked %0d results under %0d register settings.",
			sent_count, checked_count, setting_count);
		$display("Fault codes 0..6 seen: %0d %0d %0d %0d %0d %0d %0d",
			code_hits[0], code_hits[1], code_hits[2], code_hits[3],
			code_hits[4], code_hits[5], code_hits[6]);
		if (mismatch_count == 0) begin
			$display("** misaligned_access_decode_check: PASSED **");
		end else begin
			$display("** misaligned_access_decode_check: FAILED **");
		end
		$finish;
	end

endmodule

/* misaligned_access_decode_check.f */
+incdir+hdl
hdl/madc_pkg.sv
hdl/madc_decode.sv
hdl/madc_check.sv
hdl/misaligned_access_decode_check.sv
dv/tb.sv
